/* hdl/grmw_pkg.sv */
// Shared constants, payload types and index helpers for the guest radix map walker.
`timescale 1ns / 1ps

package grmw_pkg;

    // Map geometry
    localparam int LEVELS            = 4;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int PAGE_OFFSET_BITS  = 12;
    localparam int TABLE_PAGES       = 64;

    localparam int ADDR_W       = 48;
    localparam int ENTRY_W      = 48;
    localparam int OPCODE_W     = 2;
    localparam int STATUS_W     = 2;
    localparam int INDEX_W      = $clog2(ENTRIES_PER_TABLE);
    localparam int PAGE_W       = $clog2(TABLE_PAGES);
    localparam int FREE_W       = $clog2(TABLE_PAGES + 1);
    localparam int LEVEL_W      = $clog2(LEVELS);
    localparam int STORE_DEPTH  = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int STORE_ADDR_W = PAGE_W + INDEX_W;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_LOOKUP  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_MAP     = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MAP_NEW = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_TABLES  = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ADDR_W-1:0]   guest_addr;
        logic [ADDR_W-1:0]   host_addr;
    } grmw_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   found_host_addr;
    } grmw_rsp_t;

    typedef struct packed {
        logic                    en;
        logic [STORE_ADDR_W-1:0] addr;
        logic [ENTRY_W-1:0]      data;
    } store_wr_t;

    typedef struct packed {
        logic                    en;
        logic [STORE_ADDR_W-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic      valid;
        grmw_rsp_t rsp;
    } walk_done_t;

    // Table index used at a given level, top level first in the walk
    function automatic logic [INDEX_W-1:0] level_index(
        input logic [ADDR_W-1:0]  gaddr,
        input logic [LEVEL_W-1:0] level
    );
        logic [63:0] wide;
        wide = 64'(gaddr) >> (PAGE_OFFSET_BITS + int'(level) * INDEX_W);
        return wide[INDEX_W-1:0];
    endfunction

endpackage

/* hdl/grmw_store.sv */
// Table store: single write port, single registered read port.
`timescale 1ns / 1ps

module grmw_store (
    input  logic                       clk,
    input  grmw_pkg::store_wr_t        wr,
    input  grmw_pkg::store_rd_t        rd,
    output logic [grmw_pkg::ENTRY_W-1:0] rd_data
);

    logic [grmw_pkg::ENTRY_W-1:0] mem [grmw_pkg::STORE_DEPTH];
    logic [grmw_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/grmw_walk.sv */
// Walk sequencer: clearing pass, level-by-level read/modify/write, page pool.
`timescale 1ns / 1ps

module grmw_walk (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  grmw_pkg::grmw_cmd_t          cmd,
    output logic                         busy,
    output grmw_pkg::store_wr_t          store_wr,
    output grmw_pkg::store_rd_t          store_rd,
    input  logic [grmw_pkg::ENTRY_W-1:0] rd_data,
    output grmw_pkg::walk_done_t         fin
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;

    localparam logic [grmw_pkg::STORE_ADDR_W-1:0] CLR_LAST =
        grmw_pkg::STORE_ADDR_W'(grmw_pkg::STORE_DEPTH - 1);
    localparam logic [grmw_pkg::LEVEL_W-1:0] TOP_LEVEL =
        grmw_pkg::LEVEL_W'(grmw_pkg::LEVELS - 1);

    logic [1:0]                          state_reg, state_next;
    logic [grmw_pkg::STORE_ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [grmw_pkg::LEVEL_W-1:0]        level_reg, level_next;
    logic [grmw_pkg::PAGE_W-1:0]         page_reg, page_next;
    logic [grmw_pkg::FREE_W-1:0]         free_reg, free_next;
    logic [grmw_pkg::OPCODE_W-1:0]       op_reg;
    logic [grmw_pkg::ADDR_W-1:0]         gaddr_reg;
    logic [grmw_pkg::ADDR_W-1:0]         haddr_reg;

    logic                                do_map;
    logic                                entry_absent;
    logic                                pool_dry;
    logic [grmw_pkg::PAGE_W-1:0]         child;
    logic [grmw_pkg::LEVEL_W-1:0]        level_dn;

    assign busy         = (state_reg != S_IDLE);
    assign do_map       = op_reg inside {grmw_pkg::OP_MAP, grmw_pkg::OP_MAP_NEW};
    assign entry_absent = (rd_data == '0) ||
                          (rd_data >= grmw_pkg::ENTRY_W'(grmw_pkg::TABLE_PAGES));
    assign pool_dry     = (free_reg >= grmw_pkg::FREE_W'(grmw_pkg::TABLE_PAGES));
    assign child        = entry_absent ? free_reg[grmw_pkg::PAGE_W-1:0]
                                       : rd_data[grmw_pkg::PAGE_W-1:0];
    assign level_dn     = level_reg - 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        level_next    = level_reg;
        page_next     = page_reg;
        free_next     = free_reg;
        store_wr      = '0;
        store_rd      = '0;
        fin           = '0;

        case (state_reg)
            S_CLEAR:
            begin
                // zero one entry per cycle
                store_wr.en   = 1'b1;
                store_wr.addr = clr_addr_reg;
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    store_rd.en   = 1'b1;
                    store_rd.addr = {grmw_pkg::PAGE_W'(0),
                                     grmw_pkg::level_index(cmd.guest_addr, TOP_LEVEL)};
                    level_next    = TOP_LEVEL;
                    page_next     = '0;
                    state_next    = S_WALK;
                end
            end

            S_WALK:
            begin
                if (level_reg != '0)
                begin
                    if (entry_absent && !do_map)
                    begin
                        fin.valid      = 1'b1;
                        fin.rsp.status = grmw_pkg::ST_NOT_MAPPED;
                        state_next     = S_IDLE;
                    end
                    else if (entry_absent && pool_dry)
                    begin
                        fin.valid      = 1'b1;
                        fin.rsp.status = grmw_pkg::ST_NO_TABLES;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        if (entry_absent)
                        begin
                            // link a fresh page; pages past the pool top are still zero
                            store_wr.en   = 1'b1;
                            store_wr.addr = {page_reg,
                                             grmw_pkg::level_index(gaddr_reg, level_reg)};
                            store_wr.data = grmw_pkg::ENTRY_W'(free_reg);
                            free_next     = free_reg + 1'b1;
                        end
                        store_rd.en   = 1'b1;
                        store_rd.addr = {child, grmw_pkg::level_index(gaddr_reg, level_dn)};
                        page_next     = child;
                        level_next    = level_dn;
                    end
                end
                else
                begin
                    fin.valid  = 1'b1;
                    state_next = S_IDLE;
                    if (!do_map)
                    begin
                        if (rd_data == '0)
                        begin
                            fin.rsp.status = grmw_pkg::ST_NOT_MAPPED;
                        end
                        else
                        begin
                            fin.rsp.status          = grmw_pkg::ST_OK;
                            fin.rsp.found_host_addr = rd_data;
                        end
                    end
                    else if (op_reg == grmw_pkg::OP_MAP_NEW && rd_data != '0)
                    begin
                        fin.rsp.status = grmw_pkg::ST_ALREADY;
                    end
                    else
                    begin
                        store_wr.en    = 1'b1;
                        store_wr.addr  = {page_reg, grmw_pkg::level_index(gaddr_reg, '0)};
                        store_wr.data  = haddr_reg;
                        fin.rsp.status = grmw_pkg::ST_OK;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            level_reg    <= '0;
            page_reg     <= '0;
            free_reg     <= grmw_pkg::FREE_W'(1);
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            level_reg    <= level_next;
            page_reg     <= page_next;
            free_reg     <= free_next;
        end
    end

    // hold the command for the length of the walk
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg    <= cmd.opcode;
            gaddr_reg <= cmd.guest_addr;
            haddr_reg <= cmd.host_addr;
        end
    end

endmodule

/* hdl/guest_radix_map_walker.sv */
// Top level of the guest radix map walker: store, walk sequencer, result register.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive cmd and raise start; the beat is taken at a rising edge
//   where start is high and busy is low. Opcode lookup (or the unused code) walks
//   the map read-only; map writes host_addr into the leaf, taking zeroed table
//   pages from the pool for missing levels; map-new refuses a nonzero leaf.
//   Result channel: done is high for exactly one cycle with result valid; the
//   receiver cannot hold it off and must take it in that cycle.
//   Timing: the walk reads one level per cycle from the single-port-read store,
//   and done is registered from the walk's last step, on a full walk the step at
//   level 0; a walk that stops early at a missing level returns sooner.
//   busy is high while a walk runs, so a new command is taken only after the
//   previous walk has ended, while the previous result sits in the output
//   register. Each level costs one store read; allocation writes share the cycle.
//   Reset: rst_n clears the pool to one page (the root) and then runs a clearing
//   pass that zeroes all TABLE_PAGES * ENTRIES_PER_TABLE entries (32768) one
//   entry per cycle; busy is high throughout and no command is taken.

module guest_radix_map_walker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  grmw_pkg::grmw_cmd_t cmd,
    output logic                busy,
    output logic                done,
    output grmw_pkg::grmw_rsp_t result
);

    grmw_pkg::store_wr_t          store_wr;
    grmw_pkg::store_rd_t          store_rd;
    logic [grmw_pkg::ENTRY_W-1:0] rd_data;
    grmw_pkg::walk_done_t         fin;

    logic                         done_reg;
    grmw_pkg::grmw_rsp_t          result_reg;

    grmw_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd      (store_rd),
        .rd_data (rd_data)
    );

    grmw_walk u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .store_wr (store_wr),
        .store_rd (store_rd),
        .rd_data  (rd_data),
        .fin      (fin)
    );

    // Output beat register: parts the walk from the receiver so the next
    // command can be accepted while this result is shown.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin.valid)
        begin
            result_reg <= fin.rsp;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // An accepted command always starts a walk.
    a_accept_walks: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not start a walk");

    // A result beat is shown only after the walk has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while a walk is in progress");

    // Results never come in back-to-back cycles.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    // Only a successful lookup returns an address.
    a_addr_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != grmw_pkg::ST_OK |-> result.found_host_addr == '0)
        else $error("address returned with a failing status");

endmodule
